// ===== design/utf8dec_pkg.sv =====
// shared types and constants for the utf-8 byte stream decoder
`timescale 1ns / 1ps
`default_nettype none
package utf8dec_pkg;

  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  // one decoded request from the front: flushed invalids, then an optional final result
  typedef struct packed {
    logic [1:0]  flush_cnt;
    logic        has_final;
    logic [20:0] code_point;
    logic        is_invalid;
    logic [2:0]  bytes_used;
    logic        end_of_text;
  } job_t;

  // queue status toward the back end
  typedef struct packed {
    logic valid;
    job_t head;
  } q_head_t;

endpackage
`default_nettype wire

// ===== design/utf8dec_front.sv =====
// front end: accepts text bytes, tracks the pending sequence, emits decode jobs
`timescale 1ns / 1ps
`default_nettype none
module utf8dec_front (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_fire,
  input  wire  [7:0]         text_byte,
  output logic               push,
  output utf8dec_pkg::job_t  job
);
  import utf8dec_pkg::*;

  logic [2:0]  expected_length, expected_length_next;
  logic [1:0]  bytes_seen, bytes_seen_next;
  logic [20:0] partial_value, partial_value_next;
  logic [20:0] shifted;
  logic [2:0]  seen_sum;
  logic        pending;
  logic        is_cont;

  assign pending  = (expected_length != LenNone);
  assign is_cont  = (text_byte[7:6] == 2'b10);
  assign shifted  = {partial_value[14:0], text_byte[5:0]};
  assign seen_sum = {1'b0, bytes_seen} + 3'd1;

  always_comb begin
    expected_length_next = expected_length;
    bytes_seen_next      = bytes_seen;
    partial_value_next   = partial_value;
    job                  = '0;
    if (pending && is_cont) begin
      if (seen_sum >= expected_length) begin
        job.has_final        = 1'b1;
        job.code_point       = shifted;
        job.bytes_used       = expected_length;
        expected_length_next = LenNone;
        bytes_seen_next      = 2'd0;
        partial_value_next   = '0;
      end else begin
        bytes_seen_next    = seen_sum[1:0];
        partial_value_next = shifted;
      end
    end else begin
      // broken sequence flushes lead and taken continuations
      job.flush_cnt        = pending ? bytes_seen : 2'd0;
      expected_length_next = LenNone;
      bytes_seen_next      = 2'd0;
      partial_value_next   = '0;
      if (text_byte == 8'h00) begin
        job.has_final   = 1'b1;
        job.end_of_text = 1'b1;
      end else if (!text_byte[7]) begin
        job.has_final  = 1'b1;
        job.code_point = {14'd0, text_byte[6:0]};
        job.bytes_used = 3'd1;
      end else if (text_byte[7:5] == 3'b110) begin
        expected_length_next = LenTwo;
        bytes_seen_next      = 2'd1;
        partial_value_next   = {16'd0, text_byte[4:0]};
      end else if (text_byte[7:4] == 4'b1110) begin
        expected_length_next = LenThree;
        bytes_seen_next      = 2'd1;
        partial_value_next   = {17'd0, text_byte[3:0]};
      end else if (text_byte[7:3] == 5'b11110) begin
        expected_length_next = LenFour;
        bytes_seen_next      = 2'd1;
        partial_value_next   = {18'd0, text_byte[2:0]};
      end else begin
        job.has_final  = 1'b1;
        job.is_invalid = 1'b1;
        job.bytes_used = 3'd1;
      end
    end
  end

  assign push = in_fire && (job.has_final || (job.flush_cnt != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= LenNone;
      bytes_seen      <= 2'd0;
      partial_value   <= '0;
    end else if (in_fire) begin
      expected_length <= expected_length_next;
      bytes_seen      <= bytes_seen_next;
      partial_value   <= partial_value_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/utf8dec_queue.sv =====
// short job queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module utf8dec_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  utf8dec_pkg::job_t      push_job,
  output logic                   full,
  input  wire                    pop,
  output utf8dec_pkg::q_head_t   head
);
  import utf8dec_pkg::*;

  job_t              entries [QDepth];
  logic [QAddrW-1:0] wr_ptr;
  logic [QAddrW-1:0] rd_ptr;
  logic [QCntW-1:0]  count;

  assign full       = (count == QCntW'(QDepth));
  assign head.valid = (count != '0);
  assign head.head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/utf8dec_back.sv =====
// back end: expands each job into results and holds the output register
`timescale 1ns / 1ps
`default_nettype none
module utf8dec_back (
  input  wire                    clk,
  input  wire                    rst,
  input  utf8dec_pkg::q_head_t   head,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [23:0]            m_tdata,
  output logic [1:0]             m_tuser,
  output logic                   m_tlast
);
  import utf8dec_pkg::*;

  logic [1:0]  sub, sub_next;
  logic        load;
  logic        in_flush;
  logic        last;
  logic [20:0] cp;
  logic        inv;
  logic [2:0]  used;
  logic        eot;

  assign load     = head.valid && (!m_tvalid || m_tready);
  assign in_flush = (sub < head.head.flush_cnt);

  always_comb begin
    if (in_flush) begin
      cp   = '0;
      inv  = 1'b1;
      used = 3'd1;
      eot  = 1'b0;
      last = (sub == head.head.flush_cnt - 2'd1) && !head.head.has_final;
    end else begin
      cp   = head.head.code_point;
      inv  = head.head.is_invalid;
      used = head.head.bytes_used;
      eot  = head.head.end_of_text;
      last = 1'b1;
    end
    sub_next = last ? 2'd0 : sub + 2'd1;
  end

  assign pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sub      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        sub      <= sub_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {used, cp};
      m_tuser <= {eot, inv};
      m_tlast <= last;
    end
  end

endmodule
`default_nettype wire

// ===== design/utf8_byte_stream_decoder.sv =====
// top level of the utf-8 byte stream decoder
// path: a result goes through the job queue, then the output register, after its byte is accepted
// throughput: one byte per cycle while the queue is not full and each byte gives at
// most one result; a broken sequence gives up to four results, one per cycle from the
// back end while the output is not stalled, buffered in a four-entry job queue
// reset: synchronous, clears the pending sequence, the queue and the output valid
`timescale 1ns / 1ps
`default_nettype none
module utf8_byte_stream_decoder (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // text_byte[7:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // code_point[20:0], bytes_used[23:21]
  output logic [1:0]  m_tuser,   // is_invalid[0], end_of_text[1]
  output logic        m_tlast    // last_of_run
);
  import utf8dec_pkg::*;

  logic    full;
  logic    push;
  logic    pop;
  logic    in_fire;
  job_t    job;
  q_head_t head;

  assign s_tready = !full;
  assign in_fire  = s_tvalid && s_tready;

  utf8dec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .text_byte (s_tdata),
    .push      (push),
    .job       (job)
  );

  utf8dec_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

  utf8dec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// testbench for the utf-8 byte stream decoder: drives byte streams, predicts and checks results
`timescale 1ns / 1ps
module testbench;
  import utf8dec_pkg::*;

  typedef enum logic [1:0] {
    PhaseSteady,
    PhaseSendIdle,
    PhaseRecvStall,
    PhaseBothIdle
  } phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    phase_e     phase;
    logic       drain_first;
  } byte_req_t;

  typedef struct packed {
    logic        last_of_run;
    logic        end_of_text;
    logic [2:0]  bytes_used;
    logic        is_invalid;
    logic [20:0] code_point;
  } cp_result_t;

  localparam int WatchdogLimit = 4000;
  localparam int RandomBytes   = 196;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // text_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // code_point, bytes_used
  logic [1:0]  m_tuser;          // is_invalid, end_of_text
  logic        m_tlast;          // last_of_run

  byte_req_t  byte_q[$];
  cp_result_t expected_q[$];
  int         pending_results = 0;
  int         errors = 0;
  int         idle_cycles = 0;
  phase_e     active_phase = PhaseSteady;
  phase_e     gen_phase = PhaseSteady;
  logic       gen_drain = 1'b0;

  // decoder state of the predictor
  logic [2:0]  seq_len = LenNone;
  logic [2:0]  seq_seen = 3'd0;
  logic [20:0] seq_value = 21'd0;

  utf8_byte_stream_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int send_idle_pct(phase_e p);
    case (p)
      PhaseSendIdle: return 68;
      PhaseBothIdle: return 36;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(phase_e p);
    case (p)
      PhaseRecvStall: return 68;
      PhaseBothIdle: return 36;
      default: return 0;
    endcase
  endfunction

  function automatic void push_code(logic [20:0] cp, logic inv, logic [2:0] used, logic eot);
    cp_result_t r;
    r.code_point  = cp;
    r.is_invalid  = inv;
    r.bytes_used  = used;
    r.end_of_text = eot;
    r.last_of_run = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void clear_sequence();
    seq_len   = LenNone;
    seq_seen  = 3'd0;
    seq_value = 21'd0;
  endfunction

  function automatic void decode_fresh(logic [7:0] b);
    if (b == 8'h00) begin
      push_code(21'd0, 1'b0, 3'd0, 1'b1);
    end else if (b[7] == 1'b0) begin
      push_code({14'd0, b[6:0]}, 1'b0, 3'd1, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      seq_len   = LenTwo;
      seq_seen  = 3'd1;
      seq_value = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      seq_len   = LenThree;
      seq_seen  = 3'd1;
      seq_value = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      seq_len   = LenFour;
      seq_seen  = 3'd1;
      seq_value = {18'd0, b[2:0]};
    end else begin
      push_code(21'd0, 1'b1, 3'd1, 1'b0);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int         first;
    cp_result_t r;
    first = expected_q.size();
    if (seq_len != LenNone) begin
      if (b[7:6] == 2'b10) begin
        seq_value = {seq_value[14:0], b[5:0]};
        seq_seen  = seq_seen + 3'd1;
        if (seq_seen >= seq_len) begin
          push_code(seq_value, 1'b0, seq_len, 1'b0);
          clear_sequence();
        end
      end else begin
        // broken sequence: one invalid per byte already taken
        for (int i = 0; i < seq_seen && i < 3; i++)
          push_code(21'd0, 1'b1, 3'd1, 1'b0);
        clear_sequence();
        decode_fresh(b);
      end
    end else begin
      decode_fresh(b);
    end
    if (expected_q.size() > first) begin
      r = expected_q[expected_q.size() - 1];
      r.last_of_run = 1'b1;
      expected_q[expected_q.size() - 1] = r;
    end
  endfunction

  function automatic void check_result();
    cp_result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: code_point %0h tuser %0b", m_tdata[20:0], m_tuser);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (m_tdata[20:0] !== want.code_point) begin
      $error("code_point expected %0h actual %0h", want.code_point, m_tdata[20:0]);
      errors++;
    end
    if (m_tuser[0] !== want.is_invalid) begin
      $error("is_invalid expected %0d actual %0d", want.is_invalid, m_tuser[0]);
      errors++;
    end
    if (m_tdata[23:21] !== want.bytes_used) begin
      $error("bytes_used expected %0d actual %0d", want.bytes_used, m_tdata[23:21]);
      errors++;
    end
    if (m_tuser[1] !== want.end_of_text) begin
      $error("end_of_text expected %0d actual %0d", want.end_of_text, m_tuser[1]);
      errors++;
    end
    if (m_tlast !== want.last_of_run) begin
      $error("last_of_run expected %0d actual %0d", want.last_of_run, m_tlast);
      errors++;
    end
  endfunction

  function automatic void add_byte(logic [7:0] b);
    byte_req_t req;
    req.text_byte   = b;
    req.phase       = gen_phase;
    req.drain_first = gen_drain;
    gen_drain = 1'b0;
    byte_q.push_back(req);
  endfunction

  function automatic logic [7:0] lead_of(int len);
    case (len)
      2: return {3'b110, 5'($urandom_range(31))};
      3: return {4'b1110, 4'($urandom_range(15))};
      default: return {5'b11110, 3'($urandom_range(7))};
    endcase
  endfunction

  function automatic logic [7:0] continuation();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  // one random chunk: mostly well-formed characters, some breaks and noise
  function automatic void add_chunk();
    int         pick;
    int         len;
    int         taken;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 25) begin
      add_byte(8'($urandom_range(127, 1)));
    end else if (pick < 75) begin
      len = (pick < 42) ? 2 : (pick < 58) ? 3 : 4;
      add_byte(lead_of(len));
      for (int i = 1; i < len; i++)
        add_byte(continuation());
    end else if (pick < 82) begin
      add_byte(8'h00);
    end else if (pick < 92) begin
      len   = $urandom_range(4, 2);
      taken = $urandom_range(len - 2);
      add_byte(lead_of(len));
      for (int i = 0; i < taken; i++)
        add_byte(continuation());
      b = 8'($urandom_range(255));
      if (b[7:6] == 2'b10)
        b[6] = 1'b1;
      add_byte(b);
    end else begin
      add_byte(8'($urandom_range(255)));
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (byte_q.size() > 0 &&
          (!byte_q[0].drain_first || (!s_tvalid && pending_results == 0)) &&
          $urandom_range(99) >= send_idle_pct(byte_q[0].phase)) begin
        s_tvalid     <= 1'b1;
        s_tdata      <= byte_q[0].text_byte;
        active_phase <= byte_q[0].phase;
        void'(byte_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_stall_pct(active_phase);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      clear_sequence();
      pending_results <= 0;
    end else begin
      if (s_tvalid && s_tready)
        decode_byte(s_tdata);
      if (m_tvalid && m_tready)
        check_result();
      pending_results <= expected_q.size();
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int count;
    int base;
    // ascii, two, three and four byte forms, the largest 21-bit value
    add_byte(8'h41); add_byte(8'h7F);
    add_byte(8'hC3); add_byte(8'hA9);
    add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC);
    add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h80);
    add_byte(8'hF7); add_byte(8'hBF); add_byte(8'hBF); add_byte(8'hBF);
    // stray continuation, a bad lead
    add_byte(8'h80); add_byte(8'hFF);
    // break after three bytes of a four byte sequence
    add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h41);
    // end of text while pending, then a plain end of text
    add_byte(8'hE2); add_byte(8'h82); add_byte(8'h00); add_byte(8'h00);

    base  = byte_q.size();
    count = 0;
    while (count < RandomBytes) begin
      if (phase_e'((count * 4) / RandomBytes) != gen_phase || count == 0) begin
        gen_phase = phase_e'((count * 4) / RandomBytes);
        gen_drain = 1'b1;
      end
      add_chunk();
      count = byte_q.size() - base;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || s_tvalid || pending_results != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);

    if (expected_q.size() != 0) begin
      $error("results missing: %0d still expected", expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
